// ===== hw/rtl/bdfs_pkg.sv =====
`timescale 1ns / 1ps

package bdfs_pkg;

    // Binary input and the BCD field that a full conversion fills
    localparam int BIN_W  = 16;
    localparam int BCD_DIGITS = 5;
    localparam int BCD_W  = 4 * BCD_DIGITS;

    // Places that can reach the display, and the width of a place index
    localparam int PLACES = 4;
    localparam int POS_W  = 2;
    localparam int FRAME_W = 8;

    // Shift-add-3 conversion split into equal register stages
    localparam int STEPS_PER_STAGE = 4;
    localparam int STAGE_COUNT = BIN_W / STEPS_PER_STAGE;

    // Work word that moves down the conversion pipeline
    typedef struct packed {
        logic             valid;
        logic [BCD_W-1:0] bcd;
        logic [BIN_W-1:0] bin;
    } t_dd_word;

    // One shift-add-3 step: correct each digit, then shift in the next binary bit
    function automatic t_dd_word dabble_step(input t_dd_word w);
        t_dd_word         r;
        logic [BCD_W-1:0] fixed;
        fixed = w.bcd;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (fixed[4*d +: 4] >= 4'd5) begin
                fixed[4*d +: 4] = fixed[4*d +: 4] + 4'd3;
            end
        end
        r.valid = w.valid;
        r.bcd   = {fixed[BCD_W-2:0], w.bin[BIN_W-1]};
        r.bin   = {w.bin[BIN_W-2:0], 1'b0};
        return r;
    endfunction

endpackage

// ===== hw/rtl/bdfs_dabble_stage.sv =====
`timescale 1ns / 1ps

module bdfs_dabble_stage
    import bdfs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dd_word i_up,
    output logic     o_up_ready,
    output t_dd_word o_dn,
    input  logic     i_dn_ready
);

    t_dd_word r_word;
    logic     r_valid;
    t_dd_word n_word;

    // Run this stage's share of conversion steps on the incoming word
    always_comb begin
        n_word = i_up;
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            n_word = dabble_step(n_word);
        end
    end

    // Take a new word when empty or when the current one moves on
    assign o_up_ready = !r_valid || i_dn_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up.valid;
        end
    end

    // Hold payload unless a transfer loads it
    always_ff @(posedge i_clk) begin
        if (o_up_ready && i_up.valid) begin
            r_word <= n_word;
        end
    end

    always_comb begin
        o_dn       = r_word;
        o_dn.valid = r_valid;
    end

endmodule

// ===== hw/rtl/bdfs_frame_serializer.sv =====
`timescale 1ns / 1ps

module bdfs_frame_serializer
    import bdfs_pkg::*;
#(
    parameter int DIGITS = 4
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dd_word           i_word,
    output logic               o_in_ready,
    output logic               o_strobe,
    output logic [FRAME_W-1:0] o_frame,
    output logic [POS_W-1:0]   o_position,
    output logic               o_last
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGITS - 1);

    logic                  r_active;
    logic [POS_W-1:0]      r_pos;
    logic [4*PLACES-1:0]   r_digits;
    logic                  at_last;
    logic                  load;

    assign at_last    = (r_pos == LAST_POS);
    assign o_in_ready = !r_active || at_last;
    assign load       = o_in_ready && i_word.valid;

    // Advance one place per cycle; reload from the pipeline after the final place
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
        end else if (load) begin
            r_active <= 1'b1;
            r_pos    <= '0;
        end else if (r_active) begin
            r_active <= !at_last;
            r_pos    <= at_last ? '0 : r_pos + 1'b1;
        end
    end

    // Shift the next digit into the low nibble each frame
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_digits <= i_word.bcd[4*PLACES-1:0];
        end else if (r_active) begin
            r_digits <= {4'd0, r_digits[4*PLACES-1:4]};
        end
    end

    assign o_strobe   = r_active;
    assign o_frame    = {r_digits[3:0], 4'b1000 >> r_pos};
    assign o_position = r_pos;
    assign o_last     = at_last;

    // Frames of one value come in order, one per cycle
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && !at_last) |=> (r_active && r_pos == $past(r_pos) + 1'b1))
        else $error("frame sequence skipped a place");

    // A value's first frame is always the ones place
    a_first_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_active && r_pos == '0))
        else $error("new value did not start at ones place");

    // Digit nibble stays decimal and select stays one-hot
    a_frame_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_digits[3:0] <= 4'd9 && $onehot(o_frame[3:0])))
        else $error("malformed display frame");

    // Never start a new value over a frame still pending
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && !at_last) |-> !load)
        else $error("value loaded before previous frames finished");

endmodule

// ===== hw/rtl/bcd_digit_frame_sequencer.sv =====
`timescale 1ns / 1ps
// Path: a transferred value passes through the four conversion stages and the frame
//   register before its first frame, then the rest follow at one frame per cycle.
// Flow: the single frame output takes a value only when idle or at its last frame;
//   the conversion pipeline takes a new value every cycle while it has room.
// Reset (synchronous, active low) empties the pipeline and the frame register.
// The receiver cannot stall: each frame is valid for exactly one cycle.

module bcd_digit_frame_sequencer
    import bdfs_pkg::*;
#(
    parameter int DIGIT_COUNT = 4
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [BIN_W-1:0]   i_value,
    output logic               busy,
    output logic               o_strobe,
    output logic [FRAME_W-1:0] o_frame,
    output logic [POS_W-1:0]   o_position,
    output logic               o_last
);

    localparam int DIGITS = (DIGIT_COUNT < 1) ? 1 :
                            (DIGIT_COUNT > PLACES) ? PLACES : DIGIT_COUNT;

    t_dd_word stage_word [0:STAGE_COUNT];
    logic     stage_ready [0:STAGE_COUNT];

    // Feed the raw value into the first conversion stage
    always_comb begin
        stage_word[0].valid = start && !busy;
        stage_word[0].bcd   = '0;
        stage_word[0].bin   = i_value;
    end

    assign busy = !stage_ready[0];

    // Chain the conversion stages
    for (genvar g = 0; g < STAGE_COUNT; g++) begin : g_stage
        bdfs_dabble_stage u_stage (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_up       (stage_word[g]),
            .o_up_ready (stage_ready[g]),
            .o_dn       (stage_word[g+1]),
            .i_dn_ready (stage_ready[g+1])
        );
    end

    // Emit one frame per place
    bdfs_frame_serializer #(
        .DIGITS (DIGITS)
    ) u_serializer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_word     (stage_word[STAGE_COUNT]),
        .o_in_ready (stage_ready[STAGE_COUNT]),
        .o_strobe   (o_strobe),
        .o_frame    (o_frame),
        .o_position (o_position),
        .o_last     (o_last)
    );

endmodule
